// ===== hw/rtl/vn2d_pkg.sv =====
package vn2d_pkg;

    // Fixed widths of the payload fields.
    localparam int COORD_W = 13;
    localparam int PIXEL_W = 8;
    localparam int SEED_W  = 32;

    // Defaults for the top-level parameters.
    localparam int OCTAVES_DEF    = 15;
    localparam int COORD_BITS_DEF = 13;

    // Register stages inside one octave slice, and the accumulator width.
    localparam int OCT_LAT = 11;
    localparam int ACC_W   = 36;

    // Hash constants.
    localparam logic [31:0] HASH_MUL_C = 32'd15731;
    localparam logic [31:0] HASH_ADD_A = 32'd789221;
    localparam logic [31:0] HASH_ADD_B = 32'd1376312589;
    localparam logic [31:0] HASH_MASK  = 32'h7fffffff;
    localparam logic [31:0] Q30_ONE    = 32'h40000000;
    localparam int          FRAC_ONE   = 65536;

    // Q30 gain of octave oct, evaluated at elaboration only.
    function automatic longint gain_q30(input int oct);
        longint g;
        g = longint'(1) << 30;
        for (int k = 1; k <= oct; k++)
        begin
            g = (g * 100 + 50) / 101;
        end
        return g;
    endfunction

    // Signed halving of a 32-bit word with truncation toward zero.
    function automatic logic [31:0] halve32(input logic [31:0] t);
        logic [31:0] r;
        r = {t[31], t[31:1]};
        if (t[31] && t[0])
        begin
            r = r + 32'd1;
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/value_noise_2d_pixel_top.sv =====
// Multi-octave 2-D lattice value noise, one 8-bit pixel per coordinate.
//
// Input channel: in_valid, in_stall, x_coord, y_coord. A coordinate transfer
// happens at a rising clock edge with in_valid high and in_stall low.
// Output channel: out_valid, out_stall, pixel, with the same transfer rule.
// Configuration: cfg_we writes cfg_wdata into the seed register at the next
// rising edge. Write it only while no item is in flight.
//
// Throughput is one pixel per clock while the output is not stalled. Every
// octave has its own hash slice, and each slice is a pipeline of four corner
// hashes, so nothing is shared. There are fifteen register stages: one input
// register, eleven octave stages, two stages of the octave sum, and the clamp
// and scale stage that loads the output. The input register loads at the
// transfer edge itself.
//
// Reset clears all valid bits and sets the seed to zero. When the receiver
// stalls a valid result, the whole pipeline holds in place and in_stall is
// raised in the same cycle, so no item is dropped or repeated.
module value_noise_2d_pixel_top #(
    parameter int OCTAVES    = vn2d_pkg::OCTAVES_DEF,
    parameter int COORD_BITS = vn2d_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [vn2d_pkg::COORD_W-1:0]  x_coord,
    input  logic [vn2d_pkg::COORD_W-1:0]  y_coord,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [vn2d_pkg::PIXEL_W-1:0]  pixel,
    input  logic                          cfg_we,
    input  logic [vn2d_pkg::SEED_W-1:0]   cfg_wdata
);

    localparam int NGRP  = (OCTAVES + 3) / 4;
    localparam int NVLD  = vn2d_pkg::OCT_LAT + 3;
    localparam int AW    = vn2d_pkg::ACC_W;
    localparam logic signed [AW-1:0] Z_ONE = AW'(64'sh10000000);

    logic adv;
    logic [NVLD-1:0] vld_reg;
    logic out_valid_reg;
    logic [vn2d_pkg::SEED_W-1:0] seed_reg;
    logic [COORD_BITS-1:0] x_reg, y_reg;
    logic signed [31:0] contrib [OCTAVES];
    logic signed [AW-1:0] grp_reg [NGRP];
    logic signed [AW-1:0] grp_next [NGRP];
    logic signed [AW-1:0] total_reg, total_next;
    logic [vn2d_pkg::PIXEL_W-1:0] pixel_reg, pixel_next;
    logic signed [AW-1:0] z_cl;
    logic [29:0] z_u;
    logic [37:0] scaled;

    // The pipeline moves whenever the output register is free or is being read.
    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
            seed_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                seed_reg <= cfg_wdata;
            end
            if (adv)
            begin
                vld_reg       <= {vld_reg[NVLD-2:0], in_valid};
                out_valid_reg <= vld_reg[NVLD-1];
            end
        end
    end

    generate
        for (genvar o = 1; o <= OCTAVES; o++)
        begin : g_oct
            vn2d_octave #(
                .OCTAVES    (OCTAVES),
                .COORD_BITS (COORD_BITS),
                .OCT        (o)
            ) u_oct (
                .clk     (clk),
                .en      (adv),
                .x_coord (x_reg),
                .y_coord (y_reg),
                .seed    (seed_reg),
                .contrib (contrib[o-1])
            );
        end
    endgenerate

    // Octave sum in two registered levels: groups of four, then the groups.
    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_next[g] = '0;
            for (int j = 0; j < 4; j++)
            begin
                if (g * 4 + j < OCTAVES)
                begin
                    grp_next[g] = grp_next[g] + AW'(contrib[g * 4 + j]);
                end
            end
        end
        total_next = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            total_next = total_next + grp_reg[g];
        end
        // Clamp to [-1,1] in Q28, then pixel = floor(255 * (z + 1) / 2).
        z_cl = total_reg;
        if (total_reg > Z_ONE)
        begin
            z_cl = Z_ONE;
        end
        if (total_reg < -Z_ONE)
        begin
            z_cl = -Z_ONE;
        end
        z_u        = 30'(z_cl + Z_ONE);
        scaled     = ({8'd0, z_u} << 8) - {8'd0, z_u};
        pixel_next = scaled[36:29];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg     <= COORD_BITS'(x_coord);
            y_reg     <= COORD_BITS'(y_coord);
            grp_reg   <= grp_next;
            total_reg <= total_next;
            pixel_reg <= pixel_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel     = pixel_reg;

    // Back-pressure is the only source of input stall.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall))
        else $error("input stalled without a stalled result");

    // An accepted coordinate enters the first valid stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> vld_reg[0])
        else $error("accepted coordinate lost at pipeline entry");

    // A frozen pipeline keeps all of its valid bits.
    assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("valid bits moved during a stall");

endmodule

// ===== hw/rtl/vn2d_octave.sv =====
module vn2d_octave #(
    parameter int OCTAVES    = vn2d_pkg::OCTAVES_DEF,
    parameter int COORD_BITS = vn2d_pkg::COORD_BITS_DEF,
    parameter int OCT        = 1
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic [COORD_BITS-1:0]    x_coord,
    input  logic [COORD_BITS-1:0]    y_coord,
    input  logic [31:0]              seed,
    output logic signed [31:0]       contrib
);

    localparam int SH = OCTAVES - OCT;
    localparam logic signed [31:0] GAIN = 32'(vn2d_pkg::gain_q30(OCT));
    localparam logic [31:0] ZZ_OCT = 32'(2 * OCT);
    localparam logic [31:0] RMASK = 32'((64'd1 << SH) - 64'd1);
    localparam int WD = 8;

    logic [31:0] xw, yw, xc, yc, rx, ry;
    logic [16:0] fx, fy;

    assign xw = 32'(x_coord);
    assign yw = 32'(y_coord);
    assign xc = xw >> SH;
    assign yc = yw >> SH;
    assign rx = xw & RMASK;
    assign ry = yw & RMASK;

    // The fraction is the in-cell remainder rescaled to Q16.
    generate
        if (SH <= 16)
        begin : g_frac_up
            assign fx = 17'(rx << (16 - SH));
            assign fy = 17'(ry << (16 - SH));
        end
        else
        begin : g_frac_dn
            assign fx = 17'(rx >> (SH - 16));
            assign fy = 17'(ry >> (SH - 16));
        end
    endgenerate

    logic signed [18:0] d_xy, w00_s, w11_s;
    logic [16:0] w_next [4];
    logic [31:0] a_c [4];
    logic [31:0] b_c [4];

    always_comb
    begin
        d_xy  = 19'(fx) - 19'(fy);
        w00_s = 19'(vn2d_pkg::FRAC_ONE) - 19'(fx) - 19'(fy);
        w11_s = 19'(fx) + 19'(fy) - 19'(vn2d_pkg::FRAC_ONE);
        w_next[0] = (w00_s > 0) ? 17'(w00_s) : 17'd0;
        w_next[1] = (d_xy > 0) ? 17'(d_xy) : 17'd0;
        w_next[2] = (d_xy < 0) ? 17'(-d_xy) : 17'd0;
        w_next[3] = (w11_s > 0) ? 17'(w11_s) : 17'd0;
        a_c[0] = xc;
        a_c[1] = xc + 32'd1;
        a_c[2] = xc;
        a_c[3] = xc + 32'd1;
        b_c[0] = yc;
        b_c[1] = yc;
        b_c[2] = yc + 32'd1;
        b_c[3] = yc + 32'd1;
    end

    logic [31:0] s1_sum_reg [4];
    logic [31:0] s1_q_reg   [4];
    logic [31:0] inner_reg  [4];
    logic [31:0] s3_s_reg   [4];
    logic [31:0] s3_q_reg   [4];
    logic [31:0] k_reg      [4];
    logic [31:0] h5_reg     [4];
    logic [31:0] hh_reg     [4];
    logic [31:0] h6_reg     [4];
    logic [31:0] m_reg      [4];
    logic [31:0] h7_reg     [4];
    logic signed [31:0] v_reg    [4];
    logic signed [49:0] prod_reg [4];
    logic [16:0] w_dly_reg [WD][4];
    logic signed [31:0] term_reg;
    logic signed [31:0] contrib_reg;

    logic signed [51:0] sum_next;
    logic signed [63:0] tg_next;
    logic [31:0] hx [4];
    logic [31:0] n_val [4];

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            hx[c] = k_reg[c] + seed;
            n_val[c] = (h7_reg[c] * m_reg[c] + vn2d_pkg::HASH_ADD_B) & vn2d_pkg::HASH_MASK;
        end
        sum_next = 52'(prod_reg[0]) + 52'(prod_reg[1]) + 52'(prod_reg[2]) + 52'(prod_reg[3]);
        tg_next  = 64'(term_reg) * 64'(GAIN);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 4; c++)
            begin
                s1_sum_reg[c] <= (a_c[c] << 1) + (b_c[c] << 1);
                s1_q_reg[c]   <= a_c[c] << 1;
                inner_reg[c]  <= vn2d_pkg::halve32(
                    s1_sum_reg[c] * (s1_sum_reg[c] + 32'd1) + s1_q_reg[c]);
                s3_s_reg[c]   <= ZZ_OCT + inner_reg[c];
                s3_q_reg[c]   <= inner_reg[c];
                k_reg[c]      <= vn2d_pkg::halve32(
                    s3_s_reg[c] * (s3_s_reg[c] + 32'd1) + s3_q_reg[c]);
                h5_reg[c]     <= (hx[c] << 13) ^ hx[c];
                hh_reg[c]     <= h5_reg[c] * h5_reg[c];
                h6_reg[c]     <= h5_reg[c];
                m_reg[c]      <= hh_reg[c] * vn2d_pkg::HASH_MUL_C + vn2d_pkg::HASH_ADD_A;
                h7_reg[c]     <= h6_reg[c];
                v_reg[c]      <= $signed(vn2d_pkg::Q30_ONE - n_val[c]);
                prod_reg[c]   <= 50'(v_reg[c]) * 50'($signed({1'b0, w_dly_reg[WD-1][c]}));
                w_dly_reg[0][c] <= w_next[c];
                for (int d = 1; d < WD; d++)
                begin
                    w_dly_reg[d][c] <= w_dly_reg[d-1][c];
                end
            end
            term_reg    <= 32'(sum_next >>> 19);
            contrib_reg <= 32'(tg_next >>> 30);
        end
    end

    assign contrib = contrib_reg;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    // Run shape. The pipeline is about 15 stages deep, so a short drain wait
    // after the last pixel is enough before any seed change.
    localparam int PIPE_DEPTH  = 15;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_OCT       = vn2d_pkg::OCTAVES_DEF;

    typedef struct packed {
        logic [vn2d_pkg::COORD_W-1:0] x;
        logic [vn2d_pkg::COORD_W-1:0] y;
    } coord_t;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    logic [vn2d_pkg::COORD_W-1:0] x_coord;
    logic [vn2d_pkg::COORD_W-1:0] y_coord;
    logic                         out_valid;
    logic                         out_stall;
    logic [vn2d_pkg::PIXEL_W-1:0] pixel;
    logic                         cfg_we;
    logic [vn2d_pkg::SEED_W-1:0]  cfg_wdata;

    // Coordinates waiting to be sent, and pixels predicted for sent ones.
    coord_t                       coord_q[$];
    logic [vn2d_pkg::PIXEL_W-1:0] pixel_q[$];

    // Seed as seen by the predictor; it changes only while the block is empty.
    logic [31:0] noise_seed;

    // Percent chances of a gap on each side; set per phase.
    int unsigned send_gap_pct;
    int unsigned recv_stall_pct;
    int unsigned hold_off_cycles;
    bit          pause_sender;

    int unsigned errors;
    int unsigned cycle_count;

    value_noise_2d_pixel_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .x_coord   (x_coord),
        .y_coord   (y_coord),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pixel     (pixel),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Zigzag map from a signed lattice index to an unsigned code.
    function automatic logic [31:0] zz_code(input longint t);
        if (t < 0)
        begin
            return 32'((-t) * 2 - 1);
        end
        return 32'(t * 2);
    endfunction

    // Cantor pairing, wrapped to 32 bits, halved toward zero as signed.
    function automatic logic [31:0] cantor_half(input logic [31:0] p, input logic [31:0] q);
        logic [31:0] s;
        logic [31:0] t;
        int          v;
        s = p + q;
        t = s * (s + 32'd1) + q;
        v = $signed(t);
        v = v / 2;
        return 32'(v);
    endfunction

    // Lattice corner value in Q30, equal to 2^30 minus the hashed word.
    function automatic longint lattice_value(input longint a, input longint b, input int oct);
        logic [31:0] k;
        logic [31:0] h;
        logic [31:0] n;
        k = cantor_half(zz_code(oct), cantor_half(zz_code(b), zz_code(a)));
        h = k + noise_seed;
        h = (h << 13) ^ h;
        n = (h * (h * h * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7fffffff;
        return (longint'(1) << 30) - longint'(n);
    endfunction

    function automatic longint floor_div_pow2(input longint s, input int k);
        return s >>> k;
    endfunction

    function automatic longint clip_pos(input longint v);
        return (v > 0) ? v : 0;
    endfunction

    // Expected pixel for one coordinate under the current seed.
    function automatic logic [vn2d_pkg::PIXEL_W-1:0] noise_pixel(input coord_t c);
        longint acc;
        longint gain;
        longint xc;
        longint yc;
        longint fx;
        longint fy;
        longint s;
        longint term;
        longint z;
        longint rx;
        longint ry;
        int     sh;
        acc  = 0;
        gain = longint'(1) << 30;
        for (int i = 1; i <= N_OCT; i++)
        begin
            sh = N_OCT - i;
            xc = longint'(c.x) >> sh;
            yc = longint'(c.y) >> sh;
            rx = longint'(c.x) & ((longint'(1) << sh) - 1);
            ry = longint'(c.y) & ((longint'(1) << sh) - 1);
            fx = (sh <= 16) ? (rx << (16 - sh)) : (rx >> (sh - 16));
            fy = (sh <= 16) ? (ry << (16 - sh)) : (ry >> (sh - 16));
            gain = (gain * 100 + 50) / 101;
            s = lattice_value(xc, yc, i) * clip_pos(65536 - fx - fy)
              + lattice_value(xc + 1, yc, i) * clip_pos(fx - fy)
              + lattice_value(xc, yc + 1, i) * clip_pos(fy - fx)
              + lattice_value(xc + 1, yc + 1, i) * clip_pos(fx + fy - 65536);
            term = floor_div_pow2(s, 19);
            acc += floor_div_pow2(term * gain, 30);
        end
        z = acc;
        if (z > (longint'(1) << 28))
        begin
            z = longint'(1) << 28;
        end
        if (z < -(longint'(1) << 28))
        begin
            z = -(longint'(1) << 28);
        end
        return vn2d_pkg::PIXEL_W'(((z + (longint'(1) << 28)) * 255) >> 29);
    endfunction

    // Driver: offers the next queued coordinate and holds it while stalled.
    // The prediction is made at the transfer edge, so the seed in use is the
    // one that the block holds at that moment.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            x_coord  <= '0;
            y_coord  <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                pixel_q.push_back(noise_pixel(coord_q.pop_front()));
            end
            if (!in_valid || !in_stall)
            begin
                if (coord_q.size() > 0 && !pause_sender
                    && $urandom_range(99, 0) >= send_gap_pct)
                begin
                    in_valid <= 1'b1;
                    x_coord  <= coord_q[0].x;
                    y_coord  <= coord_q[0].y;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each pixel transfer and draws the stall for next cycle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pixel_q.size() == 0)
                begin
                    $display("%0t: unexpected pixel transfer, expected none, actual %0d",
                             $time, pixel);
                    errors++;
                end
                else if (pixel_q[0] !== pixel)
                begin
                    $display("%0t: pixel mismatch, expected %0d, actual %0d",
                             $time, pixel_q[0], pixel);
                    errors++;
                    void'(pixel_q.pop_front());
                end
                else
                begin
                    void'(pixel_q.pop_front());
                end
            end
            if (hold_off_cycles > 0)
            begin
                hold_off_cycles <= hold_off_cycles - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Waits until every sent coordinate has its pixel, then lets the
    // pipeline settle so a seed write cannot land on an item in flight.
    task automatic drain_pipeline();
        while (coord_q.size() > 0 || pixel_q.size() > 0 || in_valid)
        begin
            @(posedge clk);
        end
        repeat (PIPE_DEPTH + 5) @(posedge clk);
    endtask

    task automatic write_seed(input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        noise_seed = value;
        @(posedge clk);
    endtask

    function automatic void add_coord(input int unsigned x, input int unsigned y);
        coord_t c;
        c.x = vn2d_pkg::COORD_W'(x);
        c.y = vn2d_pkg::COORD_W'(y);
        coord_q.push_back(c);
    endfunction

    // Random coordinates: mostly full range, some clustered near cell edges
    // of the coarse octaves and near the corners of the field.
    task automatic add_random_coords(input int n);
        int unsigned kind;
        for (int i = 0; i < n; i++)
        begin
            kind = $urandom_range(9, 0);
            if (kind < 6)
            begin
                add_coord($urandom_range(8191, 0), $urandom_range(8191, 0));
            end
            else if (kind < 8)
            begin
                add_coord(($urandom_range(7, 0) << 10) + $urandom_range(2, 0),
                          ($urandom_range(7, 0) << 10) + $urandom_range(2, 0));
            end
            else
            begin
                add_coord($urandom_range(3, 0) ^ ($urandom_range(1, 0) ? 8191 : 0),
                          $urandom_range(3, 0) ^ ($urandom_range(1, 0) ? 8191 : 0));
            end
        end
    endtask

    initial
    begin
        errors          = 0;
        cycle_count     = 0;
        noise_seed      = '0;
        send_gap_pct    = 0;
        recv_stall_pct  = 0;
        hold_off_cycles = 0;
        pause_sender    = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        rst_n           = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset seed: field extremes, single-bit
        // patterns, the zero-fraction case and equal fractions on both axes.
        add_coord(0, 0);
        add_coord(8191, 8191);
        add_coord(8191, 0);
        add_coord(0, 8191);
        add_coord(4096, 4096);
        add_coord(1, 1);
        add_coord(1, 0);
        add_coord(0, 1);
        add_coord(4095, 4095);
        add_coord(5461, 2730);
        add_coord(2730, 5461);
        add_coord(1024, 3072);
        add_coord(8190, 1);
        add_coord(777, 777);
        drain_pipeline();

        // Extreme seeds, with a few points each.
        write_seed(32'h7fffffff);
        add_coord(0, 0);
        add_coord(8191, 8191);
        add_coord(1234, 4321);
        drain_pipeline();
        write_seed(32'h80000000);
        add_coord(0, 0);
        add_coord(8191, 8191);
        add_coord(4321, 1234);
        drain_pipeline();
        write_seed(32'hffffffff);
        add_coord(0, 0);
        add_coord(8191, 8191);
        add_coord(3000, 6000);
        drain_pipeline();

        // Phase with no idling on either side.
        write_seed($urandom);
        add_random_coords(170);
        drain_pipeline();

        // Sender idling most of the time.
        write_seed($urandom);
        send_gap_pct = 59;
        add_random_coords(170);
        drain_pipeline();

        // Receiver stalling most of the time.
        write_seed($urandom);
        send_gap_pct   = 0;
        recv_stall_pct = 59;
        add_random_coords(170);
        drain_pipeline();

        // Both sides idling now and then, with one long receiver hold-off
        // while the sender keeps offering, so the pipeline fills and stalls.
        write_seed(32'd0);
        send_gap_pct    = 15;
        recv_stall_pct  = 15;
        hold_off_cycles = 60;
        add_random_coords(170);
        drain_pipeline();

        // Sender sends a batch, pauses until every pixel has come back,
        // then resumes.
        write_seed($urandom);
        send_gap_pct   = 0;
        recv_stall_pct = 10;
        add_random_coords(80);
        while (coord_q.size() > 0)
        begin
            @(posedge clk);
        end
        pause_sender = 1'b1;
        while (pixel_q.size() > 0 || in_valid)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        pause_sender = 1'b0;
        add_random_coords(90);
        drain_pipeline();

        if (errors == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/vn2d_pkg.sv
hw/rtl/vn2d_octave.sv
hw/rtl/value_noise_2d_pixel_top.sv
test/testbench.sv
